// ===== src/pl_gold_descrambler_macros.svh =====
// -----------------------------------------------------------------------------
// PL Gold descrambler assertion macros
// Short forms for the concurrent checks used in the descrambler RTL.
// -----------------------------------------------------------------------------
`ifndef PL_GOLD_DESCRAMBLER_MACROS_SVH
`define PL_GOLD_DESCRAMBLER_MACROS_SVH

// Check sampled on the rising edge of clk, switched off while in reset.
`define PLGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check sampled on the rising edge of clk, active during reset as well.
`define PLGD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/plgd_pkg.sv =====
// -----------------------------------------------------------------------------
// PL Gold descrambler package
// Widths, LFSR taps and the jump-ahead table shared by the descrambler files.
// -----------------------------------------------------------------------------
package plgd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int LFSR_W           = 18;

  typedef logic [LFSR_W-1:0] lfsr_t;
  // Row i holds the mask whose parity gives bit i of the next state.
  typedef lfsr_t [LFSR_W-1:0] lfsr_mat_t;
  // Entry k is the x transition matrix raised to the power 2**k.
  typedef lfsr_mat_t [LFSR_W-1:0] jump_tab_t;

  localparam lfsr_t X_SEED_RST = lfsr_t'(18'h00001);
  localparam lfsr_t Y_INIT     = lfsr_t'(18'h3FFFF);
  localparam lfsr_t X_FB_TAPS  = lfsr_t'(18'h00081);
  localparam lfsr_t X_RN_TAPS  = lfsr_t'(18'h08050);
  localparam lfsr_t Y_FB_TAPS  = lfsr_t'(18'h004A1);
  localparam lfsr_t Y_RN_TAPS  = lfsr_t'(18'h0FF60);

  // Builds the table of repeated squares of the x transition matrix.
  function automatic jump_tab_t gold_jump_table();
    jump_tab_t tab;
    lfsr_mat_t m;
    lfsr_mat_t sq;
    for (int i = 0; i < LFSR_W; i++) begin
      if (i < LFSR_W - 1) begin
        m[i] = lfsr_t'(1) << (i + 1);
      end else begin
        m[i] = X_FB_TAPS;
      end
    end
    for (int k = 0; k < LFSR_W; k++) begin
      tab[k] = m;
      for (int i = 0; i < LFSR_W; i++) begin
        sq[i] = '0;
        for (int j = 0; j < LFSR_W; j++) begin
          if (m[i][j]) begin
            sq[i] = sq[i] ^ m[j];
          end
        end
      end
      m = sq;
    end
    return tab;
  endfunction

  localparam jump_tab_t JUMP_TAB = gold_jump_table();

endpackage

// ===== src/plgd_in_if.sv =====
// -----------------------------------------------------------------------------
// PL Gold descrambler input channel
// Valid/ready channel carrying one complex symbol and its frame start flag.
// -----------------------------------------------------------------------------
interface plgd_in_if #(
  parameter int SAMPLE_WIDTH = plgd_pkg::SAMPLE_WIDTH_DEF
);
  import plgd_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           frame_start;

  modport source (output valid, output sample_i, output sample_q, output frame_start,
                  input ready);
  modport sink   (input valid, input sample_i, input sample_q, input frame_start,
                  output ready);
endinterface

// ===== src/plgd_out_if.sv =====
// -----------------------------------------------------------------------------
// PL Gold descrambler output channel
// Valid/ready channel carrying one descrambled complex symbol.
// -----------------------------------------------------------------------------
interface plgd_out_if #(
  parameter int SAMPLE_WIDTH = plgd_pkg::SAMPLE_WIDTH_DEF
);
  import plgd_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_i;
  logic signed [SAMPLE_WIDTH-1:0] out_q;

  modport source (output valid, output out_i, output out_q, input ready);
  modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

// ===== src/pl_gold_descrambler.sv =====
// -----------------------------------------------------------------------------
// PL Gold descrambler
// DVB-S2 physical-layer payload descrambler with run-time Gold code selection.
// -----------------------------------------------------------------------------
// The block removes the physical-layer Gold scrambling from a stream of
// payload symbols. Each word on the input channel is one complex symbol in
// signed fixed point together with a flag marking the first payload symbol of
// a frame; each accepted word gives exactly one descrambled word on the output
// channel, in order. In steady state one word is accepted every clock cycle:
// a new word is taken in the same cycle as the previous result leaves the
// output register, and the input is held off only while that result is
// stalled by the output side. The result is presented from the output register
// in the cycle after acceptance. Writing the Gold code through the configuration
// port starts a jump-ahead that forms the x seed one code bit per cycle; the
// input is held off until the jump-ahead completes, after which words flow at
// the full rate again. The new seed is used from the next frame start onwards.
`include "pl_gold_descrambler_macros.svh"

module pl_gold_descrambler #(
  parameter int SAMPLE_WIDTH = plgd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  plgd_in_if.sink                    in_if,
  plgd_out_if.source                 out_if,
  input  logic                       cfg_we,
  input  logic [plgd_pkg::LFSR_W-1:0] cfg_wdata
);
  import plgd_pkg::*;

  localparam int CNT_W = $clog2(LFSR_W);
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_JUMP = 2'b10
  } seq_state_t;

  typedef struct packed {
    lfsr_t x;
    lfsr_t y;
  } lfsr_pair_t;

  // Negation that saturates the most negative value to the most positive one.
  function automatic logic signed [SAMPLE_WIDTH-1:0] neg_sat(
    input logic signed [SAMPLE_WIDTH-1:0] v
  );
    if (v == SMP_MIN) begin
      return SMP_MAX;
    end
    return -v;
  endfunction

  // ---------------------------------------------------------------------------
  // Seed sequencer. A Gold code write restarts the seed at one and then, for
  // each of the 18 code bits from the least significant up, multiplies the
  // seed by the matching power-of-two jump matrix when that bit is set. The
  // result equals stepping x from one as many times as the code says.
  // ---------------------------------------------------------------------------
  seq_state_t       seq_r,  seq_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  lfsr_t            code_r, code_nxt;
  lfsr_t            seed_r, seed_nxt;
  lfsr_t            seed_jump;
  lfsr_mat_t        jump_mat;

  assign jump_mat = JUMP_TAB[cnt_r];

  always_comb begin
    for (int i = 0; i < LFSR_W; i++) begin
      seed_jump[i] = ^(jump_mat[i] & seed_r);
    end
  end

  always_comb begin
    seq_nxt  = seq_r;
    cnt_nxt  = cnt_r;
    code_nxt = code_r;
    seed_nxt = seed_r;
    if (cfg_we) begin
      seq_nxt  = ST_JUMP;
      cnt_nxt  = '0;
      code_nxt = cfg_wdata;
      seed_nxt = X_SEED_RST;
    end else begin
      unique case (seq_r)
        ST_IDLE: begin
        end
        ST_JUMP: begin
          if (code_r[0]) begin
            seed_nxt = seed_jump;
          end
          code_nxt = code_r >> 1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(LFSR_W - 1)) begin
            seq_nxt = ST_IDLE;
          end
        end
        default: begin
          seq_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= ST_IDLE;
      cnt_r  <= '0;
      seed_r <= X_SEED_RST;
    end else begin
      seq_r  <= seq_nxt;
      cnt_r  <= cnt_nxt;
      seed_r <= seed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  // ---------------------------------------------------------------------------
  // Handshake. Words are taken whenever the sequencer is idle and the output
  // register is empty or being emptied in this same cycle.
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic in_ready;
  logic in_acc;

  assign in_ready    = (seq_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign in_acc      = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  // ---------------------------------------------------------------------------
  // LFSR state store. The x and y registers live in a single-entry memory with
  // a registered read port. Every accepted word reads, steps and writes the
  // entry back; the read register takes the write data directly so that a word
  // in the very next cycle sees the updated state. Until the first write the
  // entry is marked invalid and reads as the reset state.
  // ---------------------------------------------------------------------------
  lfsr_pair_t lfsr_mem [1];
  lfsr_pair_t lfsr_rd_r;
  logic       lfsr_vld_r;
  lfsr_pair_t lfsr_cur;
  lfsr_pair_t lfsr_wr;

  assign lfsr_cur = lfsr_vld_r ? lfsr_rd_r : lfsr_pair_t'{x: X_SEED_RST, y: Y_INIT};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lfsr_mem[0] <= lfsr_wr;
      lfsr_rd_r   <= lfsr_wr;
    end else begin
      lfsr_rd_r   <= lfsr_mem[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_vld_r <= 1'b0;
    end else if (in_acc) begin
      lfsr_vld_r <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence generation. A frame start reloads x from the seed and y with all
  // ones before the taps are taken. Rn picks the quarter turn applied below.
  // ---------------------------------------------------------------------------
  lfsr_t      x_use, y_use;
  logic [1:0] rn;

  always_comb begin
    x_use = in_if.frame_start ? seed_r : lfsr_cur.x;
    y_use = in_if.frame_start ? Y_INIT : lfsr_cur.y;
    rn    = {(^(x_use & X_RN_TAPS)) ^ (^(y_use & Y_RN_TAPS)), x_use[0] ^ y_use[0]};
    lfsr_wr.x = {^(x_use & X_FB_TAPS), x_use[LFSR_W-1:1]};
    lfsr_wr.y = {^(y_use & Y_FB_TAPS), y_use[LFSR_W-1:1]};
  end

  // ---------------------------------------------------------------------------
  // Quarter-turn rotation by the conjugate scrambling factor: swap and negate.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] rot_i, rot_q;
  logic signed [SAMPLE_WIDTH-1:0] out_i_r, out_q_r;

  always_comb begin
    unique case (rn)
      2'd0: begin
        rot_i = in_if.sample_i;
        rot_q = in_if.sample_q;
      end
      2'd1: begin
        rot_i = in_if.sample_q;
        rot_q = neg_sat(in_if.sample_i);
      end
      2'd2: begin
        rot_i = neg_sat(in_if.sample_i);
        rot_q = neg_sat(in_if.sample_q);
      end
      default: begin
        rot_i = neg_sat(in_if.sample_q);
        rot_q = in_if.sample_i;
      end
    endcase
  end

  // Output register: loaded on every accepted word, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_i_r <= rot_i;
      out_q_r <= rot_q;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.out_i = out_i_r;
  assign out_if.out_q = out_q_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `PLGD_ASSERT(a_no_accept_in_jump, (seq_r == ST_JUMP) |-> !in_if.ready,
               "word accepted while the seed jump-ahead is running")
  `PLGD_ASSERT(a_cfg_starts_jump, cfg_we |=> (seq_r == ST_JUMP) && (cnt_r == '0),
               "gold code write did not restart the seed jump-ahead")
  `PLGD_ASSERT(a_accept_fills_out, in_acc |=> out_if.valid,
               "accepted word produced no output word")
  `PLGD_ASSERT(a_cnt_in_range, (seq_r == ST_JUMP) |-> (cnt_r <= CNT_W'(LFSR_W - 1)),
               "jump-ahead counter ran past the last code bit")
  `PLGD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (seq_r == ST_IDLE) && !out_if.valid,
                      "reset did not return the block to idle")

endmodule
